>>> rtl/bsru_pkg.sv
// shared types, register codes and reset values of the byte stream reorder unit
package bsru_pkg;

    // default depth of the group store
    localparam int MAX_GROUP_DEF = 16;

    // configuration port geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // configuration field widths
    localparam int MODE_W  = 3;
    localparam int GS_W    = 5;
    localparam int MASK_W  = 8;
    localparam int EWC_W   = 2;
    localparam int BYTE_W  = 8;

    // register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_GROUP  = 2'd1;
    localparam logic [1:0] REG_MASK   = 2'd2;
    localparam logic [1:0] REG_ENDIAN = 2'd3;

    // transform modes, codes above MODE_ENDIAN act as pass-through
    localparam logic [MODE_W-1:0] MODE_PASS   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GROUP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BITREV = 3'd2;
    localparam logic [MODE_W-1:0] MODE_XOR    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ENDIAN = 3'd4;

    // endian word width codes, the unused codes act as eight bytes
    localparam logic [EWC_W-1:0] ENDIAN_W2 = 2'd0;
    localparam logic [EWC_W-1:0] ENDIAN_W4 = 2'd1;

    // reset values
    localparam logic [MODE_W-1:0] RST_MODE   = MODE_PASS;
    localparam logic [GS_W-1:0]   RST_GROUP  = 5'd2;
    localparam logic [MASK_W-1:0] RST_MASK   = 8'hFF;
    localparam logic [EWC_W-1:0]  RST_ENDIAN = ENDIAN_W4;

    // configuration register contents
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [GS_W-1:0]   group_size;
        logic [MASK_W-1:0] xor_mask;
        logic [EWC_W-1:0]  endian_code;
    } t_cfg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic store;   // accepted byte goes into the group store
        logic single;  // accepted byte goes straight to the output register
        logic rd;      // read the next group byte from the store
        logic load;    // move the read group byte into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic grp_mode;  // a group-collecting mode is configured
        logic grp_done;  // the incoming byte closes the group
        logic grp_last;  // the byte being drained is the last of the group
        logic out_free;  // output register can take a byte this cycle
    } t_dp_sts;

endpackage

>>> rtl/bsru_regs.sv
// configuration register file with apb-style write and read access
module bsru_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsru_pkg::ADDR_W-1:0]  paddr,
    input  logic [bsru_pkg::DATA_W-1:0]  pwdata,
    output logic [bsru_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output bsru_pkg::t_cfg               o_cfg,
    output logic                         o_cfg_wr
);
    import bsru_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= RST_MODE;
            r_cfg.group_size  <= RST_GROUP;
            r_cfg.xor_mask    <= RST_MASK;
            r_cfg.endian_code <= RST_ENDIAN;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:   r_cfg.mode        <= pwdata[MODE_W-1:0];
                REG_GROUP:  r_cfg.group_size  <= pwdata[GS_W-1:0];
                REG_MASK:   r_cfg.xor_mask    <= pwdata[MASK_W-1:0];
                REG_ENDIAN: r_cfg.endian_code <= pwdata[EWC_W-1:0];
                default:    r_cfg.mode        <= r_cfg.mode;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_MODE:   prdata = DATA_W'(r_cfg.mode);
            REG_GROUP:  prdata = DATA_W'(r_cfg.group_size);
            REG_MASK:   prdata = DATA_W'(r_cfg.xor_mask);
            REG_ENDIAN: prdata = DATA_W'(r_cfg.endian_code);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg    = r_cfg;
    assign o_cfg_wr = wr_en;

endmodule

>>> rtl/bsru_ctrl.sv
// controller state machine: byte intake, group drain sequencing
module bsru_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bsru_pkg::t_dp_sts i_sts,
    output bsru_pkg::t_dp_cmd o_cmd
);
    import bsru_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   accept;

    // intake is open only between groups; per-byte modes also need output room
    assign o_in_ready = (r_state == S_IDLE) && (i_sts.grp_mode || i_sts.out_free);
    assign accept     = i_in_valid && o_in_ready;

    // datapath commands
    always_comb begin
        o_cmd.store  = accept && i_sts.grp_mode;
        o_cmd.single = accept && !i_sts.grp_mode;
        o_cmd.rd     = (r_state == S_READ);
        o_cmd.load   = (r_state == S_LOAD) && i_sts.out_free;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_sts.grp_mode && i_sts.grp_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (i_sts.out_free) begin
                        r_state <= i_sts.grp_last ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/bsru_datapath.sv
// datapath: byte transforms, group store, fill and drain counters, output register
module bsru_datapath #(
    parameter int MAX_GROUP = bsru_pkg::MAX_GROUP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsru_pkg::t_cfg              i_cfg,
    input  logic                        i_cfg_wr,
    input  logic [bsru_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_buffer_end,
    input  bsru_pkg::t_dp_cmd           i_cmd,
    output bsru_pkg::t_dp_sts           o_sts,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bsru_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_run_last,
    output logic                        o_out_buffer_end,
    output logic                        o_length_error
);
    import bsru_pkg::*;

    localparam int AW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int EW = (CW > GS_W) ? CW : GS_W;

    // group store
    logic [BYTE_W-1:0] r_mem [MAX_GROUP];
    logic [BYTE_W-1:0] r_rdata;

    // fill and drain state
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic          r_err;
    logic          r_end;

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_end;
    logic              r_out_err;

    logic              is_grp;
    logic              is_endian;
    logic [EW-1:0]     gs_ext;
    logic [CW-1:0]     grp_g;
    logic [CW-1:0]     end_g;
    logic [CW-1:0]     g_size;
    logic [CW-1:0]     fill_nxt;
    logic              short_grp;
    logic [CW-1:0]     rev_idx;
    logic [AW-1:0]     rd_addr;
    logic              grp_last;
    logic              out_free;
    logic [BYTE_W-1:0] byte_xf;

    function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

    // mode decode
    assign is_endian = (i_cfg.mode == MODE_ENDIAN);
    assign is_grp    = (i_cfg.mode == MODE_GROUP) || is_endian;

    // group size: zero acts as one, large values saturate at the store depth
    assign gs_ext = EW'(i_cfg.group_size);
    always_comb begin
        if (i_cfg.group_size == '0) begin
            grp_g = CW'(1);
        end else if (gs_ext > EW'(MAX_GROUP)) begin
            grp_g = CW'(MAX_GROUP);
        end else begin
            grp_g = CW'(gs_ext);
        end
    end

    // endian word width
    always_comb begin
        case (i_cfg.endian_code)
            ENDIAN_W2: end_g = CW'(2);
            ENDIAN_W4: end_g = CW'(4);
            default:   end_g = CW'(8);
        endcase
    end

    assign g_size    = is_endian ? end_g : grp_g;
    assign fill_nxt  = r_fill + CW'(1);
    assign short_grp = is_endian && (fill_nxt < g_size);

    // drain addressing: reversed order, or stored order for a short endian word
    assign rev_idx  = r_cnt - CW'(1) - r_idx;
    assign rd_addr  = r_err ? r_idx[AW-1:0] : rev_idx[AW-1:0];
    assign grp_last = ((r_idx + CW'(1)) == r_cnt);
    assign out_free = !r_out_valid || i_out_ready;

    // per-byte transform
    always_comb begin
        case (i_cfg.mode)
            MODE_BITREV: byte_xf = flip_bits(i_data_byte);
            MODE_XOR:    byte_xf = i_data_byte ^ i_cfg.xor_mask;
            default:     byte_xf = i_data_byte;
        endcase
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_fill[AW-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // fill count, dropped on any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cfg_wr) begin
            r_fill <= '0;
        end else if (i_cmd.store) begin
            r_fill <= (fill_nxt >= g_size || i_buffer_end) ? '0 : fill_nxt;
        end
    end

    // group capture at close, drain index advance
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (fill_nxt >= g_size || i_buffer_end)) begin
            r_cnt <= fill_nxt;
            r_idx <= '0;
            r_err <= short_grp;
            r_end <= i_buffer_end;
        end else if (i_cmd.load) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.single || i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.single) begin
            r_out_byte <= byte_xf;
            r_out_last <= 1'b1;
            r_out_end  <= i_buffer_end;
            r_out_err  <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_byte <= r_rdata;
            r_out_last <= grp_last;
            r_out_end  <= r_end && grp_last;
            r_out_err  <= r_err;
        end
    end

    always_comb begin
        o_sts.grp_mode = is_grp;
        o_sts.grp_done = (fill_nxt >= g_size) || i_buffer_end;
        o_sts.grp_last = grp_last;
        o_sts.out_free = out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_run_last       = r_out_last;
    assign o_out_buffer_end = r_out_end;
    assign o_length_error   = r_out_err;

endmodule

>>> rtl/byte_stream_reorder_unit_core.sv
// top level of the byte stream reorder unit
//
// Usage: bytes enter on the input channel (i_in_valid / o_in_ready) with
// i_buffer_end marking the last byte of a buffer; transformed bytes leave on
// the output channel (o_out_valid / i_out_ready). Registers are to be written
// over the apb-style port while the unit is idle (unenforced); writes drop held bytes.
//
// Per-byte modes (pass-through, bit reverse, xor mask): a transfer lands in
// the output register in the cycle after it is accepted; one byte per cycle
// while the receiver keeps taking them.
// Group modes (group reverse, endian swap): a group of n bytes is collected
// in the store, then each result takes two steps (store read, output load).
// Intake closes while a group drains.
//
// Reset: registers return to their defaults, the fill count and the output
// register are cleared. No clearing pass; the store is never read before
// written. When the receiver stalls the output register holds its byte, the
// drain waits, and per-byte intake stops until the register frees up.
module byte_stream_reorder_unit_core #(
    parameter int MAX_GROUP = bsru_pkg::MAX_GROUP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsru_pkg::ADDR_W-1:0]  paddr,
    input  logic [bsru_pkg::DATA_W-1:0]  pwdata,
    output logic [bsru_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bsru_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_buffer_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bsru_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_run_last,
    output logic                         o_out_buffer_end,
    output logic                         o_length_error
);
    import bsru_pkg::*;

    t_cfg    cfg;
    logic    cfg_wr;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // configuration registers
    bsru_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    // controller
    bsru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    bsru_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cfg_wr         (cfg_wr),
        .i_data_byte      (i_data_byte),
        .i_buffer_end     (i_buffer_end),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_run_last       (o_run_last),
        .o_out_buffer_end (o_out_buffer_end),
        .o_length_error   (o_length_error)
    );

endmodule

>>> rtl/bsru_checker.sv
// port-level checker for the byte stream reorder unit, bound to the top level
module bsru_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [bsru_pkg::BYTE_W-1:0] o_out_byte,
    input logic                        o_run_last,
    input logic                        o_out_buffer_end,
    input logic                        o_length_error
);
    import bsru_pkg::*;

    // a stalled output transfer keeps its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte))
        else $error("output transfer changed while stalled");

    // the buffer end always closes the run of an input
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_buffer_end |-> o_run_last)
        else $error("buffer end without run end");

    // a short endian word only ever closes a buffer
    a_err_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_error && o_run_last |-> o_out_buffer_end)
        else $error("length error run not at buffer end");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind byte_stream_reorder_unit_core bsru_checker u_bsru_checker (.*);
